[rtl/tcse_pkg.sv]
// ----------------------------------------------------------------------------
// tcse_pkg
// Shared types and constants for the ClientHello server-name extractor.
// ----------------------------------------------------------------------------
package tcse_pkg;

    localparam int unsigned MAX_BUFFER  = 16384;
    localparam int unsigned LEN_W       = 15;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] REC_VER_MAJOR = 8'h03;
    localparam logic [7:0] HS_CLIENTHELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0] NAME_HOST = 8'h00;
    localparam logic [5:0] RANDOM_LEN = 6'd34;

    typedef enum logic [1:0] {
        ST_SNI_FOUND = 2'd0,
        ST_NOT_TLS   = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef enum logic [26:0] {
        PH_IDLE     = 27'h0000001,
        PH_REC      = 27'h0000002,
        PH_HS       = 27'h0000004,
        PH_RANDOM   = 27'h0000008,
        PH_SID_LEN  = 27'h0000010,
        PH_SID      = 27'h0000020,
        PH_CS_HI    = 27'h0000040,
        PH_CS_LO    = 27'h0000080,
        PH_CS       = 27'h0000100,
        PH_COMP_LEN = 27'h0000200,
        PH_COMP     = 27'h0000400,
        PH_EXTS_HI  = 27'h0000800,
        PH_EXTS_LO  = 27'h0001000,
        PH_TYPE_HI  = 27'h0002000,
        PH_TYPE_LO  = 27'h0004000,
        PH_OLEN_HI  = 27'h0008000,
        PH_OLEN_LO  = 27'h0010000,
        PH_OSKIP    = 27'h0020000,
        PH_SLEN_HI  = 27'h0040000,
        PH_SLEN_LO  = 27'h0080000,
        PH_LIST_HI  = 27'h0100000,
        PH_LIST_LO  = 27'h0200000,
        PH_NTYPE    = 27'h0400000,
        PH_NLEN_HI  = 27'h0800000,
        PH_NLEN_LO  = 27'h1000000,
        PH_NAME     = 27'h2000000,
        PH_DONE     = 27'h4000000
    } phase_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             start;
        logic             short_buf;
        logic [LEN_W-1:0] total_len;
    } item_t;

endpackage

[rtl/tcse_front.sv]
// ----------------------------------------------------------------------------
// tcse_front
// Input side: accepts byte transfers, clamps the buffer length, flags short
// buffers and holds the classified bytes in a small queue for the parser.
// ----------------------------------------------------------------------------
module tcse_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_start,
    input  logic [14:0]            in_len,
    output logic                   q_valid,
    input  logic                   q_pop,
    output tcse_pkg::item_t        q_item
);

    tcse_pkg::item_t                   mem [tcse_pkg::QUEUE_DEPTH];
    logic [tcse_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tcse_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tcse_pkg::QCNT_W-1:0]       count_reg, count_next;
    tcse_pkg::item_t                   wr_item;
    logic                              push;
    logic                              pop;
    logic [tcse_pkg::LEN_W-1:0]        clamped;

    assign in_ready = (count_reg != tcse_pkg::QCNT_W'(tcse_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        clamped = (32'(in_len) > tcse_pkg::MAX_BUFFER)
                  ? tcse_pkg::LEN_W'(tcse_pkg::MAX_BUFFER) : in_len;
        wr_item.data_byte = in_byte;
        wr_item.start     = in_start;
        wr_item.total_len = clamped;
        wr_item.short_buf = (clamped < tcse_pkg::LEN_W'(5));
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tcse_back.sv]
// ----------------------------------------------------------------------------
// tcse_back
// Parser: walks the record, handshake and extension headers one byte a cycle
// while bytes wait and no result is stalled, and drives the result register.
// ----------------------------------------------------------------------------
module tcse_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  tcse_pkg::item_t        q_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_has,
    output logic [7:0]             out_byte,
    output logic                   out_done,
    output logic [1:0]             out_status
);

    tcse_pkg::phase_t              phase_reg, phase_next;
    logic [14:0]                   pos_reg, pos_next;
    logic [14:0]                   total_reg, total_next;
    logic [16:0]                   rec_end_reg, rec_end_next;
    logic [24:0]                   hs_end_reg, hs_end_next;
    logic [16:0]                   ext_end_reg, ext_end_next;
    logic [15:0]                   fr_reg, fr_next;
    logic [23:0]                   acc_reg, acc_next;

    logic                          ov_reg, ov_next;
    logic                          has_reg;
    logic [7:0]                    byte_reg;
    logic                          done_reg;
    logic [1:0]                    status_reg;

    logic                          em, em_has, em_done;
    logic [7:0]                    em_byte;
    tcse_pkg::status_t             em_st;

    logic                          active;
    tcse_pkg::phase_t              cur_phase;
    logic [14:0]                   cur_pos;
    logic [14:0]                   p;
    logic [7:0]                    b;
    logic [15:0]                   v16;
    logic [23:0]                   acc_sh;
    logic [15:0]                   fr_dec;
    logic [25:0]                   p_w, b_w, v_w, he_w, ee_w, acc_w;

    assign q_pop      = q_valid && (!ov_reg || out_ready);
    assign out_valid  = ov_reg;
    assign out_has    = has_reg;
    assign out_byte   = byte_reg;
    assign out_done   = done_reg;
    assign out_status = status_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        rec_end_next = rec_end_reg;
        hs_end_next  = hs_end_reg;
        ext_end_next = ext_end_reg;
        fr_next      = fr_reg;
        acc_next     = acc_reg;
        em           = 1'b0;
        em_has       = 1'b0;
        em_byte      = 8'h00;
        em_done      = 1'b0;
        em_st        = tcse_pkg::ST_SNI_FOUND;

        b         = q_item.data_byte;
        cur_phase = q_item.start ? tcse_pkg::PH_REC : phase_reg;
        cur_pos   = q_item.start ? 15'd0 : pos_reg;
        p         = cur_pos + 15'd1;
        v16       = {acc_reg[7:0], b};
        acc_sh    = {acc_reg[15:0], b};
        fr_dec    = fr_reg - 16'd1;
        p_w       = 26'(p);
        b_w       = 26'(b);
        v_w       = 26'(v16);
        acc_w     = 26'(acc_sh);
        he_w      = 26'(hs_end_reg);
        ee_w      = 26'(ext_end_reg);

        if (q_item.start)
        begin
            active       = !q_item.short_buf;
            total_next   = q_item.total_len;
            rec_end_next = '0;
            hs_end_next  = '0;
            ext_end_next = '0;
            fr_next      = '0;
            acc_next     = '0;
            phase_next   = tcse_pkg::PH_REC;
            pos_next     = 15'd0;
            if (q_item.short_buf)
            begin
                pos_next   = 15'd1;
                phase_next = tcse_pkg::PH_DONE;
                em         = 1'b1;
                em_done    = 1'b1;
                em_st      = tcse_pkg::ST_NOT_TLS;
            end
        end
        else
        begin
            active = (phase_reg != tcse_pkg::PH_IDLE) && (pos_reg < total_reg);
        end

        if (active)
        begin
            pos_next = p;
            unique case (cur_phase)
                tcse_pkg::PH_REC:
                begin
                    if ((cur_pos == 15'd0 && b != tcse_pkg::REC_HANDSHAKE)
                        || (cur_pos == 15'd1 && b != tcse_pkg::REC_VER_MAJOR))
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_NOT_TLS;
                    end
                    else if (cur_pos == 15'd3)
                    begin
                        acc_next = 24'(b);
                    end
                    else if (cur_pos == 15'd4)
                    begin
                        if (v_w < 26'd4 || 26'(total_next) < 26'd5 + v_w)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            rec_end_next = 17'd5 + 17'(v16);
                            acc_next     = '0;
                            phase_next   = tcse_pkg::PH_HS;
                        end
                    end
                end
                tcse_pkg::PH_HS:
                begin
                    if (cur_pos == 15'd5)
                    begin
                        acc_next = '0;
                        if (b != tcse_pkg::HS_CLIENTHELLO)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sh;
                        if (cur_pos == 15'd8)
                        begin
                            if (26'd9 + acc_w > 26'(rec_end_reg)
                                || p_w + 26'(tcse_pkg::RANDOM_LEN) > 26'd9 + acc_w)
                            begin
                                phase_next = tcse_pkg::PH_DONE;
                                em = 1'b1; em_done = 1'b1;
                                em_st = tcse_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                hs_end_next = 25'(26'd9 + acc_w);
                                fr_next     = 16'(tcse_pkg::RANDOM_LEN);
                                phase_next  = tcse_pkg::PH_RANDOM;
                            end
                        end
                    end
                end
                tcse_pkg::PH_RANDOM:
                begin
                    fr_next = fr_dec;
                    if (fr_dec == '0)
                    begin
                        if (p_w + 26'd1 > he_w)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            phase_next = tcse_pkg::PH_SID_LEN;
                        end
                    end
                end
                tcse_pkg::PH_SID_LEN, tcse_pkg::PH_COMP_LEN:
                begin
                    if (p_w + b_w > he_w || (b == 8'h00 && p_w + 26'd2 > he_w))
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else if (b == 8'h00)
                    begin
                        phase_next = (cur_phase == tcse_pkg::PH_SID_LEN)
                                     ? tcse_pkg::PH_CS_HI : tcse_pkg::PH_EXTS_HI;
                    end
                    else
                    begin
                        fr_next    = 16'(b);
                        phase_next = (cur_phase == tcse_pkg::PH_SID_LEN)
                                     ? tcse_pkg::PH_SID : tcse_pkg::PH_COMP;
                    end
                end
                tcse_pkg::PH_SID, tcse_pkg::PH_COMP:
                begin
                    fr_next = fr_dec;
                    if (fr_dec == '0)
                    begin
                        if (p_w + 26'd2 > he_w)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            phase_next = (cur_phase == tcse_pkg::PH_SID)
                                         ? tcse_pkg::PH_CS_HI : tcse_pkg::PH_EXTS_HI;
                        end
                    end
                end
                tcse_pkg::PH_CS_HI:
                begin
                    acc_next   = 24'(b);
                    phase_next = tcse_pkg::PH_CS_LO;
                end
                tcse_pkg::PH_CS_LO:
                begin
                    if (p_w + v_w > he_w || (v16 == '0 && p_w + 26'd1 > he_w))
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else if (v16 == '0)
                    begin
                        phase_next = tcse_pkg::PH_COMP_LEN;
                    end
                    else
                    begin
                        fr_next    = v16;
                        phase_next = tcse_pkg::PH_CS;
                    end
                end
                tcse_pkg::PH_CS:
                begin
                    fr_next = fr_dec;
                    if (fr_dec == '0)
                    begin
                        if (p_w + 26'd1 > he_w)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            phase_next = tcse_pkg::PH_COMP_LEN;
                        end
                    end
                end
                tcse_pkg::PH_EXTS_HI, tcse_pkg::PH_TYPE_HI, tcse_pkg::PH_OLEN_HI,
                tcse_pkg::PH_SLEN_HI, tcse_pkg::PH_LIST_HI, tcse_pkg::PH_NLEN_HI:
                begin
                    acc_next   = 24'(b);
                    phase_next = tcse_pkg::phase_t'({cur_phase[25:0], 1'b0});
                end
                tcse_pkg::PH_EXTS_LO:
                begin
                    if (p_w + v_w > he_w || p_w + 26'd4 > p_w + v_w)
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        ext_end_next = 17'(p_w + v_w);
                        phase_next   = tcse_pkg::PH_TYPE_HI;
                    end
                end
                tcse_pkg::PH_TYPE_LO:
                begin
                    phase_next = (v16 == tcse_pkg::EXT_SERVER_NAME)
                                 ? tcse_pkg::PH_SLEN_HI : tcse_pkg::PH_OLEN_HI;
                end
                tcse_pkg::PH_OLEN_LO:
                begin
                    if (p_w + v_w > ee_w || (v16 == '0 && p_w + 26'd4 > ee_w))
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else if (v16 == '0)
                    begin
                        phase_next = tcse_pkg::PH_TYPE_HI;
                    end
                    else
                    begin
                        fr_next    = v16;
                        phase_next = tcse_pkg::PH_OSKIP;
                    end
                end
                tcse_pkg::PH_OSKIP:
                begin
                    fr_next = fr_dec;
                    if (fr_dec == '0)
                    begin
                        if (p_w + 26'd4 > ee_w)
                        begin
                            phase_next = tcse_pkg::PH_DONE;
                            em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            phase_next = tcse_pkg::PH_TYPE_HI;
                        end
                    end
                end
                tcse_pkg::PH_SLEN_LO:
                begin
                    if (p_w + v_w > ee_w || v16 < 16'd5)
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        fr_next    = v16;
                        phase_next = tcse_pkg::PH_LIST_HI;
                    end
                end
                tcse_pkg::PH_LIST_LO:
                begin
                    if (v_w + 26'd2 > 26'(fr_reg) || v16 < 16'd3)
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        fr_next    = v16;
                        phase_next = tcse_pkg::PH_NTYPE;
                    end
                end
                tcse_pkg::PH_NTYPE:
                begin
                    if (b != tcse_pkg::NAME_HOST)
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        phase_next = tcse_pkg::PH_NLEN_HI;
                    end
                end
                tcse_pkg::PH_NLEN_LO:
                begin
                    if (26'd3 + v_w > 26'(fr_reg) || v16 == '0)
                    begin
                        phase_next = tcse_pkg::PH_DONE;
                        em = 1'b1; em_done = 1'b1; em_st = tcse_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        fr_next    = v16;
                        phase_next = tcse_pkg::PH_NAME;
                    end
                end
                tcse_pkg::PH_NAME:
                begin
                    fr_next = fr_dec;
                    em      = 1'b1;
                    em_has  = 1'b1;
                    em_byte = b;
                    if (fr_dec == '0)
                    begin
                        em_done    = 1'b1;
                        phase_next = tcse_pkg::PH_DONE;
                    end
                end
                tcse_pkg::PH_IDLE, tcse_pkg::PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (q_pop && em)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && em)
        begin
            has_reg    <= em_has;
            byte_reg   <= em_byte;
            done_reg   <= em_done;
            status_reg <= em_done ? em_st : tcse_pkg::ST_SNI_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tcse_pkg::PH_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            rec_end_reg <= '0;
            hs_end_reg  <= '0;
            ext_end_reg <= '0;
            fr_reg      <= '0;
            acc_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (q_pop)
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                total_reg   <= total_next;
                rec_end_reg <= rec_end_next;
                hs_end_reg  <= hs_end_next;
                ext_end_reg <= ext_end_next;
                fr_reg      <= fr_next;
                acc_reg     <= acc_next;
            end
        end
    end

endmodule

[rtl/tls_client_hello_sni_extractor.sv]
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor
// Pulls the server name out of a captured ClientHello, one byte per transfer.
//
// Input stream: one buffer byte per transfer; tuser marks the first byte of a
// buffer and restarts parsing, and the buffer length rides along in tdata.
// Output stream: host-name bytes (tuser high) and one final status transfer
// (tlast high); the last name byte and the found status share one transfer.
// Each accepted byte is queued, then parsed into the result register.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// single-byte parser step; a four-entry queue sits between input and parser.
// When the receiver stalls, the result register holds and the queue fills;
// s_axis_tready drops once four bytes are waiting.
// Reset clears the queue, the parser state and the output valid; bytes are
// ignored until a byte with the start flag arrives.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte[7:0], buffer_length[22:8]
    input  logic        s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // name_byte[7:0], status[9:8]
    output logic        m_axis_tuser,   // has_byte
    output logic        m_axis_tlast    // done_res
);

    logic            q_valid;
    logic            q_pop;
    tcse_pkg::item_t q_item;
    logic [7:0]      name_byte;
    logic [1:0]      status;

    tcse_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata[7:0]),
        .in_start (s_axis_tuser),
        .in_len   (s_axis_tdata[22:8]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    tcse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_has    (m_axis_tuser),
        .out_byte   (name_byte),
        .out_done   (m_axis_tlast),
        .out_status (status)
    );

    assign m_axis_tdata = {6'b0, status, name_byte};

endmodule

[rtl/tcse_checker.sv]
// ----------------------------------------------------------------------------
// tcse_checker
// Port-level checks on the extractor's result stream.
// ----------------------------------------------------------------------------
module tcse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_mid_is_name: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-final transfer without name byte");

    a_fail_no_name: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[9:8] != tcse_pkg::ST_SNI_FOUND
        |-> !m_axis_tuser)
        else $error("failure status carries a name byte");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == '0
                          && (m_axis_tlast || m_axis_tdata[9:8] == 2'd0))
        else $error("bad status field");

    a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("name byte set without flag");

endmodule

bind tls_client_hello_sni_extractor tcse_checker u_tcse_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/tls_client_hello_sni_extractor_tb.sv]
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor_tb
// Drives captured ClientHello buffers, byte by byte, into the extractor and
// compares every output transfer with a behavioral parser kept in the bench.
// A short table covers header errors, short buffers and an oversize length;
// random buffers follow, mostly well-formed hellos with random content and
// random cuts, mixed with noise, under several idling phases.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extractor_tb;

    typedef enum int {
        PP_IDLE, PP_REC, PP_HS, PP_RANDOM, PP_SID_LEN, PP_SID, PP_CS_HI, PP_CS_LO,
        PP_CS, PP_COMP_LEN, PP_COMP, PP_EXTS_HI, PP_EXTS_LO, PP_TYPE_HI, PP_TYPE_LO,
        PP_OLEN_HI, PP_OLEN_LO, PP_OSKIP, PP_SLEN_HI, PP_SLEN_LO, PP_LIST_HI,
        PP_LIST_LO, PP_NTYPE, PP_NLEN_HI, PP_NLEN_LO, PP_NAME, PP_DONE
    } pp_t;

    typedef struct packed {
        logic       has;
        logic [7:0] name;
        logic       done;
        logic [1:0] st;
    } sni_out_t;

    typedef struct {
        logic [7:0]  b;
        logic        start;
        logic [14:0] blen;
        logic        chk;
        sni_out_t    res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    tls_client_hello_sni_extractor dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    pp_t         ph;
    int unsigned bpos, tlen, rec_end, hs_end, ext_end, remain, acc;
    sni_out_t    sni_q[$];
    int          errors;
    int          cycles;
    int          send_idle;
    int          recv_stall;
    logic [7:0]  buf_bytes[$];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic sni_out_t mk(logic has, logic [7:0] nb, logic dn, logic [1:0] st);
        sni_out_t o;
        o.has = has;
        o.name = nb;
        o.done = dn;
        o.st = st;
        return o;
    endfunction

    function automatic void conclude(tcse_pkg::status_t st);
        ph = PP_DONE;
        sni_q = {sni_q, mk(1'b0, 8'h00, 1'b1, st)};
    endfunction

    function automatic void next_ext(int unsigned p);
        if (p + 4 > ext_end)
            conclude(tcse_pkg::ST_MALFORMED);
        else
            ph = PP_TYPE_HI;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic start, logic [14:0] blen);
        int unsigned pos, p, v;
        if (start)
        begin
            ph = PP_REC;
            bpos = 0;
            rec_end = 0;
            hs_end = 0;
            ext_end = 0;
            remain = 0;
            acc = 0;
            tlen = (blen > tcse_pkg::MAX_BUFFER) ? tcse_pkg::MAX_BUFFER : blen;
            if (tlen < 5)
            begin
                bpos = 1;
                conclude(tcse_pkg::ST_NOT_TLS);
                return;
            end
        end
        else if (ph == PP_IDLE || bpos >= tlen)
            return;
        pos = bpos;
        p = pos + 1;
        bpos = p & 32'h7FFF;
        case (ph)
            PP_REC:
            begin
                if (pos == 0 && b != tcse_pkg::REC_HANDSHAKE)
                    conclude(tcse_pkg::ST_NOT_TLS);
                else if (pos == 1 && b != tcse_pkg::REC_VER_MAJOR)
                    conclude(tcse_pkg::ST_NOT_TLS);
                else if (pos == 3) acc = b;
                else if (pos == 4)
                begin
                    v = (acc << 8) | b;
                    if (v < 4 || tlen < 5 + v) conclude(tcse_pkg::ST_MALFORMED);
                    else
                    begin
                        rec_end = 5 + v;
                        acc = 0;
                        ph = PP_HS;
                    end
                end
            end
            PP_HS:
            begin
                if (pos == 5)
                begin
                    if (b != tcse_pkg::HS_CLIENTHELLO) conclude(tcse_pkg::ST_MALFORMED);
                    else acc = 0;
                end
                else
                begin
                    acc = ((acc << 8) | b) & 32'hFFFFFF;
                    if (pos == 8)
                    begin
                        if (9 + acc > rec_end) conclude(tcse_pkg::ST_MALFORMED);
                        else
                        begin
                            hs_end = 9 + acc;
                            if (p + 34 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                            else
                            begin
                                remain = 34;
                                ph = PP_RANDOM;
                            end
                        end
                    end
                end
            end
            PP_RANDOM:
            begin
                remain--;
                if (remain == 0)
                begin
                    if (p + 1 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                    else ph = PP_SID_LEN;
                end
            end
            PP_SID_LEN, PP_COMP_LEN:
            begin
                if (p + b > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                else if (b == 0)
                begin
                    if (p + 2 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                    else ph = (ph == PP_SID_LEN) ? PP_CS_HI : PP_EXTS_HI;
                end
                else
                begin
                    remain = b;
                    ph = (ph == PP_SID_LEN) ? PP_SID : PP_COMP;
                end
            end
            PP_SID, PP_COMP:
            begin
                remain--;
                if (remain == 0)
                begin
                    if (p + 2 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                    else ph = (ph == PP_SID) ? PP_CS_HI : PP_EXTS_HI;
                end
            end
            PP_CS_HI, PP_EXTS_HI, PP_TYPE_HI, PP_OLEN_HI, PP_SLEN_HI, PP_LIST_HI,
            PP_NLEN_HI:
            begin
                acc = b;
                ph = pp_t'(ph + 1);
            end
            PP_CS_LO:
            begin
                v = (acc << 8) | b;
                if (p + v > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                else if (v == 0)
                begin
                    if (p + 1 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                    else ph = PP_COMP_LEN;
                end
                else
                begin
                    remain = v;
                    ph = PP_CS;
                end
            end
            PP_CS:
            begin
                remain--;
                if (remain == 0)
                begin
                    if (p + 1 > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                    else ph = PP_COMP_LEN;
                end
            end
            PP_EXTS_LO:
            begin
                v = (acc << 8) | b;
                if (p + v > hs_end) conclude(tcse_pkg::ST_MALFORMED);
                else
                begin
                    ext_end = p + v;
                    next_ext(p);
                end
            end
            PP_TYPE_LO:
            begin
                v = (acc << 8) | b;
                ph = (v == tcse_pkg::EXT_SERVER_NAME) ? PP_SLEN_HI : PP_OLEN_HI;
            end
            PP_OLEN_LO:
            begin
                v = (acc << 8) | b;
                if (p + v > ext_end) conclude(tcse_pkg::ST_MALFORMED);
                else if (v == 0) next_ext(p);
                else
                begin
                    remain = v;
                    ph = PP_OSKIP;
                end
            end
            PP_OSKIP:
            begin
                remain--;
                if (remain == 0) next_ext(p);
            end
            PP_SLEN_LO:
            begin
                v = (acc << 8) | b;
                if (p + v > ext_end || v < 5) conclude(tcse_pkg::ST_MALFORMED);
                else
                begin
                    remain = v;
                    ph = PP_LIST_HI;
                end
            end
            PP_LIST_LO:
            begin
                v = (acc << 8) | b;
                if (v + 2 > remain || v < 3) conclude(tcse_pkg::ST_MALFORMED);
                else
                begin
                    remain = v;
                    ph = PP_NTYPE;
                end
            end
            PP_NTYPE:
            begin
                if (b != tcse_pkg::NAME_HOST) conclude(tcse_pkg::ST_MALFORMED);
                else ph = PP_NLEN_HI;
            end
            PP_NLEN_LO:
            begin
                v = (acc << 8) | b;
                if (3 + v > remain || v == 0) conclude(tcse_pkg::ST_MALFORMED);
                else
                begin
                    remain = v;
                    ph = PP_NAME;
                end
            end
            PP_NAME:
            begin
                remain--;
                if (remain == 0)
                begin
                    ph = PP_DONE;
                    sni_q = {sni_q, mk(1'b1, b, 1'b1, tcse_pkg::ST_SNI_FOUND)};
                end
                else
                    sni_q = {sni_q, mk(1'b1, b, 1'b0, tcse_pkg::ST_SNI_FOUND)};
            end
            default: ;
        endcase
    endfunction

    task automatic send(logic [7:0] b, logic start, logic [14:0] blen);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, blen, b};
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_byte(b, start, blen);
    endtask

    task automatic send_buffer(int unsigned blen_field);
        for (int i = 0; i < buf_bytes.size(); i++)
            send(buf_bytes[i], i == 0, blen_field[14:0]);
    endtask

    // random ClientHello; corrupt at a random spot or cut short now and then
    task automatic build_hello();
        int unsigned sid, cs, comp, nlen, others, olen, hl, el;
        logic [7:0] body[$];
        logic [7:0] exts[$];
        sid = ($urandom_range(3) == 0) ? $urandom_range(32) : 0;
        cs = $urandom_range(4);
        comp = $urandom_range(2);
        nlen = $urandom_range(1, 12);
        others = $urandom_range(2);
        exts = {};
        for (int k = 0; k < others; k++)
        begin
            olen = $urandom_range(3);
            exts = {exts, 8'($urandom_range(255)), 8'($urandom_range(1, 255)), 8'h00,
                    8'(olen)};
            repeat (olen) exts = {exts, 8'($urandom_range(255))};
        end
        if ($urandom_range(4) != 0)
        begin
            exts = {exts, 8'h00, 8'h00, 8'h00, 8'(nlen + 5), 8'h00, 8'(nlen + 3),
                    tcse_pkg::NAME_HOST, 8'h00, 8'(nlen)};
            repeat (nlen) exts = {exts, 8'($urandom_range(255))};
        end
        body = {};
        repeat (34) body = {body, 8'($urandom_range(255))};
        body = {body, 8'(sid)};
        repeat (sid) body = {body, 8'($urandom_range(255))};
        body = {body, 8'h00, 8'(cs * 2)};
        repeat (cs * 2) body = {body, 8'($urandom_range(255))};
        body = {body, 8'(comp)};
        repeat (comp) body = {body, 8'($urandom_range(255))};
        el = exts.size();
        body = {body, 8'(el >> 8), 8'(el & 8'hFF)};
        body = {body, exts};
        hl = body.size();
        buf_bytes = {8'h16, 8'h03, 8'h01, 8'h00, 8'(hl + 4), tcse_pkg::HS_CLIENTHELLO,
                     8'h00, 8'h00, 8'(hl)};
        buf_bytes = {buf_bytes, body};
        if ($urandom_range(3) == 0)
            buf_bytes[$urandom_range(buf_bytes.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(5) == 0)
            buf_bytes = buf_bytes[0:$urandom_range(buf_bytes.size() - 1)];
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sni_out_t got, want;
            got = mk(m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[9:8]);
            if (sni_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = sni_q.pop_front();
                if (got.has !== want.has || got.name !== want.name
                    || got.done !== want.done || got.st !== want.st)
                begin
                    $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        end
        if (rst_n)
            m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    row_t rows[$];

    initial
    begin
        row_t r;
        errors = 0;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        ph = PP_IDLE;
        bpos = 0;
        tlen = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte, short buffers, bad header bytes, oversize length
        rows = '{
            '{8'hFF, 1'b0, 15'h7FFF, 1'b0, '0},
            '{8'h16, 1'b1, 15'd0, 1'b1, mk(1'b0, 8'h00, 1'b1, tcse_pkg::ST_NOT_TLS)},
            '{8'h16, 1'b1, 15'd4, 1'b1, mk(1'b0, 8'h00, 1'b1, tcse_pkg::ST_NOT_TLS)},
            '{8'h00, 1'b0, 15'd0, 1'b0, '0},
            '{8'h00, 1'b1, 15'd5, 1'b1, mk(1'b0, 8'h00, 1'b1, tcse_pkg::ST_NOT_TLS)},
            '{8'h16, 1'b1, 15'h7FFF, 1'b0, '0},
            '{8'hFF, 1'b0, 15'd0, 1'b1, mk(1'b0, 8'h00, 1'b1, tcse_pkg::ST_NOT_TLS)},
            '{8'h16, 1'b1, 15'd5, 1'b0, '0},
            '{8'h03, 1'b0, 15'd0, 1'b0, '0},
            '{8'h01, 1'b0, 15'd0, 1'b0, '0},
            '{8'h00, 1'b0, 15'd0, 1'b0, '0},
            '{8'h03, 1'b0, 15'd0, 1'b1, mk(1'b0, 8'h00, 1'b1, tcse_pkg::ST_MALFORMED)},
            '{8'h55, 1'b0, 15'd0, 1'b0, '0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            send(r.b, r.start, r.blen);
            if (r.chk && (sni_q.size() == 0 || sni_q[$] !== r.res))
            begin
                $display("%0t: table row %0d, expected %h, actual %h", $time, i, r.res,
                         sni_q.size() ? sni_q[$] : '0);
                errors++;
            end
        end
        // random hellos, mostly well-formed, to exercise the name path
        repeat (3)
        begin
            build_hello();
            send_buffer(buf_bytes.size());
        end
        s_axis_tvalid <= 1'b0;
        while (sni_q.size() != 0) @(posedge clk);

        for (int phz = 0; phz < 4; phz++)
        begin
            send_idle = (phz == 1 || phz == 3) ? ((phz == 1) ? 72 : 6) : 0;
            recv_stall = (phz == 2) ? 72 : ((phz == 3) ? 6 : 0);
            for (int n = 0; n < 390;)
            begin
                int pick;
                pick = $urandom_range(9);
                if (pick < 7)
                begin
                    build_hello();
                    send_buffer(($urandom_range(7) == 0) ? $urandom_range(16384, 32767)
                                : buf_bytes.size() + $urandom_range(0, 3));
                end
                else
                begin
                    buf_bytes = {};
                    repeat ($urandom_range(1, 12))
                        buf_bytes = {buf_bytes, 8'($urandom_range(255))};
                    if (pick == 8) buf_bytes[0] = 8'h16;
                    send_buffer($urandom_range(0, 15));
                end
                n += buf_bytes.size();
            end
            s_axis_tvalid <= 1'b0;
            while (sni_q.size() != 0) @(posedge clk);
        end
        send_idle = 0;
        recv_stall = 0;
        repeat (20) @(posedge clk);
        if (errors == 0 && sni_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
